// ----- rtl/cb_prefix_bit_shift_unit_core_macros.svh -----
// Assertion macros for the CB-prefix bit/shift unit checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef CB_PREFIX_BIT_SHIFT_UNIT_CORE_MACROS_SVH
`define CB_PREFIX_BIT_SHIFT_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CBSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbsu assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CBSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbsu assertion failed");

`endif

// ----- rtl/cbsu_pkg.sv -----
// Shared types, codes and helpers for the CB-prefix bit/shift unit.
// Used by the register file, the execute logic, the top level and the checker.
package cbsu_pkg;

  // Register file geometry: B C D E H L A
  localparam int unsigned SlotCount = 7;
  localparam int unsigned SlotW     = 3;

  localparam logic [SlotW-1:0] SlotH = 3'd4;
  localparam logic [SlotW-1:0] SlotL = 3'd5;
  localparam logic [SlotW-1:0] SlotA = 3'd6;

  // Operand codes in opcode bits 2:0
  localparam logic [2:0] OpdMem = 3'd6;
  localparam logic [2:0] OpdA   = 3'd7;

  // Load targets
  localparam logic [2:0] LoadFlags = 3'd6;

  // Modes
  localparam logic ModeExec = 1'b0;
  localparam logic ModeLoad = 1'b1;

  // Opcode groups in bits 7:6
  localparam logic [1:0] GrpShift = 2'd0;
  localparam logic [1:0] GrpBit   = 2'd1;
  localparam logic [1:0] GrpRes   = 2'd2;
  localparam logic [1:0] GrpSet   = 2'd3;

  // Rotate/shift kinds in bits 5:3
  localparam logic [2:0] ShRlc  = 3'd0;
  localparam logic [2:0] ShRrc  = 3'd1;
  localparam logic [2:0] ShRl   = 3'd2;
  localparam logic [2:0] ShRr   = 3'd3;
  localparam logic [2:0] ShSla  = 3'd4;
  localparam logic [2:0] ShSra  = 3'd5;
  localparam logic [2:0] ShSwap = 3'd6;
  localparam logic [2:0] ShSrl  = 3'd7;

  // Flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // One input item
  typedef struct packed {
    logic       mode;
    logic [7:0] opcode;
    logic [7:0] mem_byte;
    logic [2:0] load_index;
    logic [7:0] load_value;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0]  result_value;
    logic [3:0]  flags_out;
    logic        mem_write;
    logic [15:0] mem_addr;
  } result_t;

  // State update from the execute logic to the register file
  typedef struct packed {
    logic             reg_we;
    logic [SlotW-1:0] reg_slot;
    logic [7:0]       reg_value;
    logic [3:0]       flags;
  } wb_t;

  // Map an operand or load code onto a register file slot (A sits after L)
  function automatic logic [SlotW-1:0] slot_of(input logic [2:0] code);
    logic [SlotW-1:0] slot;
    slot = (code == OpdA) ? SlotA : code;
    return slot;
  endfunction

endpackage

// ----- rtl/cbsu_regfile.sv -----
// Register file B C D E H L A plus the Z N H C flags.
// Depends on cbsu_pkg for slot geometry and the write-back struct.
module cbsu_regfile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  cbsu_pkg::wb_t             wb_i,
  input  logic [cbsu_pkg::SlotW-1:0] rd_slot_i,
  output logic [7:0]                rd_data_o,
  output logic [7:0]                h_o,
  output logic [7:0]                l_o,
  output logic [3:0]                flags_o
);

  logic [7:0] regs_q [cbsu_pkg::SlotCount];
  logic [3:0] flags_q;

  // Update registers and flags on each executed transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(cbsu_pkg::SlotCount); i++) begin
        regs_q[i] <= 8'h00;
      end
      flags_q <= 4'h0;
    end else if (we_i) begin
      if (wb_i.reg_we) begin
        regs_q[wb_i.reg_slot] <= wb_i.reg_value;
      end
      flags_q <= wb_i.flags;
    end
  end

  // Operand read plus fixed taps for the HL address
  assign rd_data_o = regs_q[rd_slot_i];
  assign h_o       = regs_q[cbsu_pkg::SlotH];
  assign l_o       = regs_q[cbsu_pkg::SlotL];
  assign flags_o   = flags_q;

endmodule

// ----- rtl/cbsu_exec.sv -----
// Combinational execute logic: rotate/shift, BIT/RES/SET and loads.
// Depends on cbsu_pkg for codes, item/result types and the write-back struct.
module cbsu_exec (
  input  cbsu_pkg::item_t   item_i,
  input  logic [7:0]        operand_i,
  input  logic [7:0]        h_i,
  input  logic [7:0]        l_i,
  input  logic [3:0]        flags_i,
  output cbsu_pkg::result_t result_o,
  output cbsu_pkg::wb_t     wb_o
);

  logic [2:0] code;
  logic [2:0] bit_n;
  logic [1:0] grp;
  logic       is_mem;
  logic [7:0] v;
  logic [7:0] mask;
  logic [7:0] sh_r;
  logic       sh_c;
  logic       c_in;
  logic [7:0] value;
  logic [3:0] flags_nx;

  assign code   = item_i.opcode[2:0];
  assign bit_n  = item_i.opcode[5:3];
  assign grp    = item_i.opcode[7:6];
  assign is_mem = (code == cbsu_pkg::OpdMem);
  assign v      = is_mem ? item_i.mem_byte : operand_i;
  assign mask   = 8'h01 << bit_n;
  assign c_in   = flags_i[cbsu_pkg::FlagC];

  // Rotate and shift unit
  always_comb begin
    case (bit_n)
      cbsu_pkg::ShRlc:  begin sh_c = v[7]; sh_r = {v[6:0], v[7]}; end
      cbsu_pkg::ShRrc:  begin sh_c = v[0]; sh_r = {v[0], v[7:1]}; end
      cbsu_pkg::ShRl:   begin sh_c = v[7]; sh_r = {v[6:0], c_in}; end
      cbsu_pkg::ShRr:   begin sh_c = v[0]; sh_r = {c_in, v[7:1]}; end
      cbsu_pkg::ShSla:  begin sh_c = v[7]; sh_r = {v[6:0], 1'b0}; end
      cbsu_pkg::ShSra:  begin sh_c = v[0]; sh_r = {v[7], v[7:1]}; end
      cbsu_pkg::ShSwap: begin sh_c = 1'b0; sh_r = {v[3:0], v[7:4]}; end
      cbsu_pkg::ShSrl:  begin sh_c = v[0]; sh_r = {1'b0, v[7:1]}; end
      default:          begin sh_c = v[0]; sh_r = {1'b0, v[7:1]}; end
    endcase
  end

  // Select the group result and its flags, then the write-back
  always_comb begin
    wb_o = '0;
    case (grp)
      cbsu_pkg::GrpShift: begin
        value    = sh_r;
        flags_nx = {(sh_r == 8'h00), 1'b0, 1'b0, sh_c};
      end
      cbsu_pkg::GrpBit: begin
        value    = v;
        flags_nx = {((v & mask) == 8'h00), 1'b0, 1'b1, c_in};
      end
      cbsu_pkg::GrpRes: begin
        value    = v & ~mask;
        flags_nx = flags_i;
      end
      cbsu_pkg::GrpSet: begin
        value    = v | mask;
        flags_nx = flags_i;
      end
      default: begin
        value    = v;
        flags_nx = flags_i;
      end
    endcase

    result_o.mem_addr = {h_i, l_i};
    if (item_i.mode == cbsu_pkg::ModeLoad) begin
      result_o.mem_write = 1'b0;
      if (item_i.load_index == cbsu_pkg::LoadFlags) begin
        result_o.result_value = {item_i.load_value[7:4], 4'h0};
        wb_o.flags            = item_i.load_value[7:4];
      end else begin
        result_o.result_value = item_i.load_value;
        wb_o.flags            = flags_i;
        wb_o.reg_we           = 1'b1;
        wb_o.reg_slot         = cbsu_pkg::slot_of(item_i.load_index);
        wb_o.reg_value        = item_i.load_value;
      end
    end else begin
      result_o.result_value = value;
      result_o.mem_write    = is_mem && (grp != cbsu_pkg::GrpBit);
      wb_o.flags            = flags_nx;
      wb_o.reg_we           = !is_mem && (grp != cbsu_pkg::GrpBit);
      wb_o.reg_slot         = cbsu_pkg::slot_of(code);
      wb_o.reg_value        = value;
    end
    result_o.flags_out = wb_o.flags;
  end

endmodule

// ----- rtl/cb_prefix_bit_shift_unit_core.sv -----
// CB-prefix rotate/shift/bit unit. Takes one item per clock unless a downstream
// stall holds it: an item in the input register reads the register file, is
// executed and updates the registers and flags as it moves into the result
// register, so the next item already sees the updated state. The result
// register is released whenever the downstream side does not stall, and the
// input stalls only while both the input and result registers are held by a
// downstream stall.
// Depends on cbsu_pkg, cbsu_regfile and cbsu_exec.
module cb_prefix_bit_shift_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  mem_byte_i,
  input  logic [2:0]  load_index_i,
  input  logic [7:0]  load_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  result_value_o,
  output logic [3:0]  flags_out_o,
  output logic        mem_write_o,
  output logic [15:0] mem_addr_o
);

  logic              in_valid_q;
  cbsu_pkg::item_t   item_q;
  logic              out_valid_q;
  cbsu_pkg::result_t res_q;

  logic              out_free;
  logic              advance;
  logic              in_take;
  cbsu_pkg::result_t res_d;
  cbsu_pkg::wb_t     wb;
  logic [7:0]        operand;
  logic [7:0]        reg_h;
  logic [7:0]        reg_l;
  logic [3:0]        flags;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{mode:       mode_i,
                  opcode:     opcode_i,
                  mem_byte:   mem_byte_i,
                  load_index: load_index_i,
                  load_value: load_value_i};
    end
  end

  cbsu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (advance),
    .wb_i      (wb),
    .rd_slot_i (cbsu_pkg::slot_of(item_q.opcode[2:0])),
    .rd_data_o (operand),
    .h_o       (reg_h),
    .l_o       (reg_l),
    .flags_o   (flags)
  );

  cbsu_exec u_exec (
    .item_i    (item_q),
    .operand_i (operand),
    .h_i       (reg_h),
    .l_i       (reg_l),
    .flags_i   (flags),
    .result_o  (res_d),
    .wb_o      (wb)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q.result_value;
  assign flags_out_o    = res_q.flags_out;
  assign mem_write_o    = res_q.mem_write;
  assign mem_addr_o     = res_q.mem_addr;

endmodule

// ----- rtl/cbsu_checker.sv -----
// Port-level checker for the CB-prefix bit/shift unit, bound to the top level.
// Depends on cbsu_pkg and the assertion macros header.
`include "cb_prefix_bit_shift_unit_core_macros.svh"

module cbsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        mode_i,
  input logic [2:0]  load_index_i,
  input logic [7:0]  load_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  result_value_o,
  input logic [3:0]  flags_out_o,
  input logic        mem_write_o
);

  // A held result keeps its payload
  `CBSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                    out_valid_o && out_stall_i,
                    out_valid_o && $stable(result_value_o) && $stable(flags_out_o))

  // Input never stalls while the result side can drain
  `CBSU_ASSERT_IMPLY(a_no_needless_stall, clk_i, rst_ni,
                     !out_valid_o || !out_stall_i,
                     !in_stall_o)

  // A flags load passes the input and result registers and shows up when nothing blocks it
  `CBSU_ASSERT_NEXT(a_flags_load, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && (mode_i == cbsu_pkg::ModeLoad) &&
                    (load_index_i == cbsu_pkg::LoadFlags) ##1 (!out_valid_o || !out_stall_i),
                    out_valid_o && !mem_write_o &&
                    (flags_out_o == $past(load_value_i[7:4], 2)) &&
                    (result_value_o[3:0] == 4'h0))

endmodule

bind cb_prefix_bit_shift_unit_core cbsu_checker u_cbsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .mode_i         (mode_i),
  .load_index_i   (load_index_i),
  .load_value_i   (load_value_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .flags_out_o    (flags_out_o),
  .mem_write_o    (mem_write_o)
);
